@@ src/parabola_closest_point_descent_assert.svh @@
// assertion macros for the descent block checker
`ifndef PARABOLA_CLOSEST_POINT_DESCENT_ASSERT_SVH
`define PARABOLA_CLOSEST_POINT_DESCENT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PCD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcd assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define PCD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcd assertion failed");

`endif

@@ src/pcd_pkg.sv @@
`default_nettype none
package pcd_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 10;
  localparam int LIMIT_BITS     = 10;
  localparam int ADDR_BITS      = 5;

  typedef logic signed [31:0] fx_t;

  localparam logic [16:0] STEP_RESET  = 17'd655;
  localparam logic [30:0] THR_RESET   = 31'd66;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 10'd100;

  typedef enum logic [2:0] {
    REG_SQUARE   = 3'd0,
    REG_LINEAR   = 3'd1,
    REG_CONSTANT = 3'd2,
    REG_STEP     = 3'd3,
    REG_LIMIT    = 3'd4,
    REG_THRESH   = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_XX, MUL_LX, MUL_QS, MUL_EXEX, MUL_EYEY, MUL_QX, MUL_ED, MUL_SG
  } mul_sel_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SQ, OP_ACC, OP_CURVE, OP_EY, OP_DIST,
    OP_ERR, OP_DERIV, OP_GRAD, OP_STEP, OP_EVAL, OP_OUT
  } dp_op_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    dp_op_t   op;
    logic     converged;
  } dp_cmd_t;

  typedef struct packed {
    logic close;
  } dp_status_t;

  typedef struct packed {
    fx_t         square;
    fx_t         linear;
    fx_t         constant;
    logic [16:0] step;
    logic [30:0] thresh;
  } cfg_t;

  function automatic fx_t sat_add(input fx_t a, input fx_t b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) sat_add = s[32] ? 32'sh80000000 : 32'sh7fffffff;
    else sat_add = s[31:0];
  endfunction

  function automatic fx_t sat_sub(input fx_t a, input fx_t b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) sat_sub = s[32] ? 32'sh80000000 : 32'sh7fffffff;
    else sat_sub = s[31:0];
  endfunction

endpackage
`default_nettype wire

@@ src/pcd_req_if.sv @@
`default_nettype none
interface pcd_req_if;
  import pcd_pkg::*;
  logic valid;
  logic ready;
  fx_t  target_x;
  fx_t  target_y;
  fx_t  start_x;
  modport source (output valid, target_x, target_y, start_x, input ready);
  modport sink (input valid, target_x, target_y, start_x, output ready);
endinterface
`default_nettype wire

@@ src/pcd_res_if.sv @@
`default_nettype none
interface pcd_res_if;
  import pcd_pkg::*;
  logic        valid;
  logic        ready;
  fx_t         nearest_x;
  fx_t         nearest_y;
  logic [30:0] squared_distance;
  logic        converged;
  modport source (output valid, nearest_x, nearest_y, squared_distance, converged,
                  input ready);
  modport sink (input valid, nearest_x, nearest_y, squared_distance, converged,
                output ready);
endinterface
`default_nettype wire

@@ src/parabola_closest_point_descent.sv @@
// Closest point on y = a*x^2 + b*x + c by gradient descent, signed Q16.16.
// Channels: req carries one request (target_x, target_y, start_x) under
// valid/ready; res returns nearest_x, nearest_y, squared_distance and
// converged under valid/ready. Curve coefficients, step, iteration limit and
// stop threshold are written over the APB port; the user must write them only
// while no request is in work, as the block itself does not enforce this. A
// search runs at most as many iterations as the iteration limit, 100 after
// reset, and stops earlier when the threshold ends it. One shared 33x33
// multiplier sequenced by the controller sets the pace for the initial
// distance and every iteration. One request is in work at a time; the next
// is taken once the result sits in the output register.
// Reset clears the controller and the result valid and loads the register
// reset values. When the receiver stalls, the result holds in the output
// register; a finished search then waits until that register frees up.
`default_nettype none
module parabola_closest_point_descent
  import pcd_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  pcd_req_if.sink                   req,
  pcd_res_if.source                 res,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  cfg_t                  cfg;
  logic [COUNT_BITS-1:0] limit;
  dp_cmd_t               cmd;
  dp_status_t            status;

  pcd_regs #(.COUNT_BITS(COUNT_BITS)) u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg, .limit
  );

  pcd_ctrl #(.COUNT_BITS(COUNT_BITS)) u_ctrl (
    .clk, .rst,
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .limit, .status, .cmd
  );

  pcd_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .cmd, .cfg,
    .in_target_x (req.target_x),
    .in_target_y (req.target_y),
    .in_start_x  (req.start_x),
    .status,
    .out_x    (res.nearest_x),
    .out_y    (res.nearest_y),
    .out_dist (res.squared_distance),
    .out_conv (res.converged)
  );

endmodule
`default_nettype wire

@@ src/pcd_regs.sv @@
`default_nettype none
module pcd_regs
  import pcd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_BITS-1:0]  paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output cfg_t                       cfg,
  output logic [COUNT_BITS-1:0]      limit
);

  logic [COUNT_BITS-1:0] limit_wr;
  logic [2:0]            idx;
  logic                  wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    for (int i = 0; i < COUNT_BITS; i++) begin
      limit_wr[i] = (i < LIMIT_BITS) ? pwdata[i] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.square   <= '0;
      cfg.linear   <= '0;
      cfg.constant <= '0;
      cfg.step     <= STEP_RESET;
      cfg.thresh   <= THR_RESET;
      limit        <= COUNT_BITS'(LIMIT_RESET);
    end else if (wr) begin
      unique case (idx)
        REG_SQUARE:   cfg.square   <= pwdata;
        REG_LINEAR:   cfg.linear   <= pwdata;
        REG_CONSTANT: cfg.constant <= pwdata;
        REG_STEP:     cfg.step     <= pwdata[16:0];
        REG_LIMIT:    limit        <= limit_wr;
        REG_THRESH:   cfg.thresh   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SQUARE:   prdata = cfg.square;
      REG_LINEAR:   prdata = cfg.linear;
      REG_CONSTANT: prdata = cfg.constant;
      REG_STEP:     prdata = {15'd0, cfg.step};
      REG_LIMIT:    prdata = 32'(limit);
      REG_THRESH:   prdata = {1'b0, cfg.thresh};
      default:      prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ src/pcd_datapath.sv @@
`default_nettype none
module pcd_datapath
  import pcd_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic       clk,
  input  wire dp_cmd_t    cmd,
  input  wire cfg_t       cfg,
  input  wire fx_t        in_target_x,
  input  wire fx_t        in_target_y,
  input  wire fx_t        in_start_x,
  output dp_status_t      status,
  output fx_t             out_x,
  output fx_t             out_y,
  output logic [30:0]     out_dist,
  output logic            out_conv
);

  localparam logic signed [65:0] MAXV = 66'sd2147483647;
  localparam logic signed [65:0] MINV = -66'sd2147483648;

  fx_t px, py, x, f, sq, acc, e, d, g, ey, ex, r;
  logic [31:0]        prev;
  logic signed [65:0] prod;
  logic signed [65:0] sh;
  logic signed [32:0] ma, mb;
  fx_t                mr;
  fx_t                u;
  logic signed [33:0] diff;
  logic [33:0]        adiff;

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_XX:   begin ma = {x[31], x};                     mb = {x[31], x};   end
      MUL_LX:   begin ma = {cfg.linear[31], cfg.linear};   mb = {x[31], x};   end
      MUL_QS:   begin ma = {cfg.square[31], cfg.square};   mb = {sq[31], sq}; end
      MUL_EXEX: begin ma = {ex[31], ex};                   mb = {ex[31], ex}; end
      MUL_EYEY: begin ma = {ey[31], ey};                   mb = {ey[31], ey}; end
      MUL_QX:   begin ma = {cfg.square[31], cfg.square};   mb = {x[31], x};   end
      MUL_ED:   begin ma = {e[31], e};                     mb = {d[31], d};   end
      MUL_SG:   begin ma = {16'd0, cfg.step};              mb = {g[31], g};   end
      default:  begin ma = '0;                             mb = '0;           end
    endcase
  end

  // floor shift, then clamp to 32 bits
  assign sh = prod >>> FRAC_BITS;
  always_comb begin
    if (sh > MAXV) mr = 32'sh7fffffff;
    else if (sh < MINV) mr = 32'sh80000000;
    else mr = sh[31:0];
  end

  assign u     = sat_sub(x, px);
  assign diff  = $signed({2'b00, r}) - $signed({2'b00, prev});
  assign adiff = diff[33] ? 34'(-diff) : 34'(diff);
  assign status.close = adiff < {3'd0, cfg.thresh};

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    unique case (cmd.op)
      OP_LOAD: begin
        px   <= in_target_x;
        py   <= in_target_y;
        x    <= in_start_x;
        prev <= '1;
      end
      OP_SQ:    sq <= mr;
      OP_ACC:   acc <= mr;
      OP_CURVE: begin
        f  <= sat_add(sat_add(mr, acc), cfg.constant);
        ex <= sat_sub(px, x);
      end
      OP_EY:    ey <= sat_sub(py, f);
      OP_DIST:  r <= sat_add(mr, acc);
      OP_ERR: begin
        e   <= sat_sub(f, py);
        acc <= sat_add(u, u);
      end
      OP_DERIV: d <= sat_add(sat_add(mr, mr), cfg.linear);
      OP_GRAD:  g <= sat_add(sat_add(mr, mr), acc);
      OP_STEP:  x <= sat_sub(x, mr);
      OP_EVAL: begin
        if (!status.close) prev <= r;
      end
      OP_OUT: begin
        out_x    <= x;
        out_y    <= f;
        out_dist <= r[30:0];
        out_conv <= cmd.converged;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ src/pcd_ctrl.sv @@
`default_nettype none
module pcd_ctrl
  import pcd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire logic [COUNT_BITS-1:0] limit,
  input  wire dp_status_t            status,
  output dp_cmd_t                    cmd
);

  typedef enum logic [4:0] {
    IDLE, D0, D1, D2, D3, D4, D5, D6, CHECK,
    S0, S1, S2, S3, S4, S5, EVAL, FIN
  } state_t;

  state_t                state;
  logic [COUNT_BITS-1:0] count;
  logic                  first;
  logic                  conv;
  logic                  fin_go;

  assign in_ready = (state == IDLE);
  assign fin_go   = (state == FIN) && (!out_valid || out_ready);

  always_comb begin
    cmd.mul_sel   = MUL_NONE;
    cmd.op        = OP_NONE;
    cmd.converged = conv;
    unique case (state)
      IDLE:  if (in_valid) cmd.op = OP_LOAD;
      D0:    cmd.mul_sel = MUL_XX;
      D1:    begin cmd.op = OP_SQ;  cmd.mul_sel = MUL_LX;   end
      D2:    begin cmd.op = OP_ACC; cmd.mul_sel = MUL_QS;   end
      D3:    cmd.op = OP_CURVE;
      D4:    begin cmd.op = OP_EY;  cmd.mul_sel = MUL_EXEX; end
      D5:    begin cmd.op = OP_ACC; cmd.mul_sel = MUL_EYEY; end
      D6:    cmd.op = OP_DIST;
      S0:    begin cmd.op = OP_ERR; cmd.mul_sel = MUL_QX;   end
      S1:    cmd.op = OP_DERIV;
      S2:    cmd.mul_sel = MUL_ED;
      S3:    cmd.op = OP_GRAD;
      S4:    cmd.mul_sel = MUL_SG;
      S5:    cmd.op = OP_STEP;
      EVAL:  cmd.op = OP_EVAL;
      FIN:   if (fin_go) cmd.op = OP_OUT;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      first     <= 1'b0;
      conv      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fin_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        IDLE: if (in_valid) begin
          state <= D0;
          count <= '0;
          first <= 1'b1;
        end
        D0: state <= D1;
        D1: state <= D2;
        D2: state <= D3;
        D3: state <= D4;
        D4: state <= D5;
        D5: state <= D6;
        D6: begin
          state <= first ? CHECK : EVAL;
          first <= 1'b0;
        end
        CHECK: begin
          if (count < limit) state <= S0;
          else begin
            conv  <= 1'b0;
            state <= FIN;
          end
        end
        S0: state <= S1;
        S1: state <= S2;
        S2: state <= S3;
        S3: state <= S4;
        S4: state <= S5;
        S5: state <= D0;
        EVAL: begin
          count <= count + 1'b1;
          if (status.close) begin
            conv  <= 1'b1;
            state <= FIN;
          end else begin
            state <= CHECK;
          end
        end
        FIN: if (fin_go) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/pcd_checker.sv @@
`default_nettype none
`include "parabola_closest_point_descent_assert.svh"
module pcd_checker
  import pcd_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic res_valid,
  input wire logic res_ready,
  input wire fx_t  res_x
);

  `PCD_ASSERT_NXT(res_hold, res_valid && !res_ready, res_valid && $stable(res_x))
  `PCD_ASSERT_NXT(req_one_at_a_time, req_valid && req_ready, !req_ready)
  `PCD_ASSERT_NXT(no_instant_result, req_valid && req_ready, !$rose(res_valid))
  `PCD_ASSERT_IMP(res_clear_after_reset, $past(rst), !res_valid)

endmodule

bind parabola_closest_point_descent pcd_checker u_pcd_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_x     (res.nearest_x)
);
`default_nettype wire
